### design/tgsd_pkg.sv
// Package for the tile id stream decoder: register index codes, field widths
// and the pipeline stage word types. No dependencies.
package tgsd_pkg;

   localparam int unsigned ID_W      = 29;
   localparam int unsigned NUM_W     = 24;
   localparam int unsigned COL_W     = 16;
   localparam int unsigned ROW_W     = 24;
   localparam int unsigned AREA_W    = 25;
   localparam int unsigned POS_W     = 32;
   localparam int unsigned CSR_ADR_W = 5;
   localparam int unsigned CSR_DAT_W = 32;

   localparam logic [1:0]        LAST_BYTE = 2'd3;
   localparam logic [AREA_W-1:0] AREA_MAX  = 25'h1000000;

   typedef enum logic [2:0] {
      REG_SKIP_BLANK  = 3'd0,
      REG_LAYER_WIDTH = 3'd1,
      REG_LAYER_AREA  = 3'd2,
      REG_TILE_WIDTH  = 3'd3,
      REG_TILE_HEIGHT = 3'd4,
      REG_OFFSET_X    = 3'd5,
      REG_OFFSET_Y    = 3'd6
   } csr_index_type;

   // Tile word after id assembly: id, flips and grid place.
   typedef struct packed {
      logic [ID_W-1:0]  tile_id;
      logic             flip_h;
      logic             flip_v;
      logic             flip_d;
      logic [NUM_W-1:0] tile_number;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             last;
   } grid_word_type;

   // Tile word after the multiply stage.
   typedef struct packed {
      logic [ID_W-1:0]  tile_id;
      logic             flip_h;
      logic             flip_v;
      logic             flip_d;
      logic [NUM_W-1:0] tile_number;
      logic [POS_W-1:0] prod_x;
      logic [POS_W-1:0] prod_y;
      logic             last;
   } prod_word_type;

endpackage

### design/tile_gid_stream_decoder.sv
// Tile id stream decoder top level: byte assembly, grid counters, pixel math.
// Depends on tgsd_pkg.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_data_byte
//  rsp     | out       | rsp_valid/rsp_stall | tile id, flips, number, pixel x/y, last
//  csr     | in/out    | APB psel/penable    | seven registers at 4*index
//
// One byte is taken per cycle unless req_stall is high. The fourth byte of an id enters a
// three-stage pipeline (grid place, multiply, offset add); its word passes the grid,
// multiply and output registers in order, waiting where the next stage is full, and is on rsp from the last.
// Reset (synchronous, active high) clears the byte position, partial id, counters,
// stage valid bits and the registers to their defaults.
// A stall on rsp holds the output word; req stalls only once the grid stage is full
// and cannot move on.
module tile_gid_stream_decoder
   import tgsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // byte stream in
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   // tile words out
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ID_W-1:0]      rsp_tile_id,
   output logic                 rsp_flip_horizontal,
   output logic                 rsp_flip_vertical,
   output logic                 rsp_flip_diagonal,
   output logic [NUM_W-1:0]     rsp_tile_number,
   output logic signed [POS_W-1:0] rsp_pixel_x,
   output logic signed [POS_W-1:0] rsp_pixel_y,
   output logic                 rsp_last_tile,
   // register port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_ADR_W-1:0] paddr,
   input  logic [CSR_DAT_W-1:0] pwdata,
   output logic [CSR_DAT_W-1:0] prdata,
   output logic                 pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic                skip_blank_ff;
   logic [COL_W-1:0]    layer_width_ff;
   logic [AREA_W-1:0]   layer_area_ff;
   logic [15:0]         tile_width_ff;
   logic [15:0]         tile_height_ff;
   logic [POS_W-1:0]    offset_x_ff;
   logic [POS_W-1:0]    offset_y_ff;

   csr_index_type       csr_index;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_blank_ff  <= 1'b0;
         layer_width_ff <= COL_W'(1);
         layer_area_ff  <= AREA_W'(1);
         tile_width_ff  <= 16'd1;
         tile_height_ff <= 16'd1;
         offset_x_ff    <= '0;
         offset_y_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SKIP_BLANK:  skip_blank_ff  <= pwdata[0];
            REG_LAYER_WIDTH: layer_width_ff <= pwdata[COL_W-1:0];
            REG_LAYER_AREA:  layer_area_ff  <= pwdata[AREA_W-1:0];
            REG_TILE_WIDTH:  tile_width_ff  <= pwdata[15:0];
            REG_TILE_HEIGHT: tile_height_ff <= pwdata[15:0];
            REG_OFFSET_X:    offset_x_ff    <= pwdata;
            REG_OFFSET_Y:    offset_y_ff    <= pwdata;
            default: ;   // unmapped address: drop the write
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_SKIP_BLANK:  prdata = {31'd0, skip_blank_ff};
         REG_LAYER_WIDTH: prdata = {16'd0, layer_width_ff};
         REG_LAYER_AREA:  prdata = {7'd0, layer_area_ff};
         REG_TILE_WIDTH:  prdata = {16'd0, tile_width_ff};
         REG_TILE_HEIGHT: prdata = {16'd0, tile_height_ff};
         REG_OFFSET_X:    prdata = offset_x_ff;
         REG_OFFSET_Y:    prdata = offset_y_ff;
         default:         prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline flow control: a stage advances when the next one is empty
   // or itself moving on.
   // ------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic a_adv, b_adv, c_free;

   assign c_free    = !c_valid_ff || !rsp_stall;
   assign b_adv     = b_valid_ff && c_free;
   assign a_adv     = a_valid_ff && (!b_valid_ff || c_free);
   assign req_stall = a_valid_ff && !a_adv;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Byte assembly and grid counters
   // ------------------------------------------------------------------
   logic [1:0]       byte_pos_ff,  byte_pos_in;
   logic [23:0]      partial_ff,   partial_in;
   logic [NUM_W-1:0] tile_cnt_ff,  tile_cnt_in;
   logic [COL_W-1:0] col_cnt_ff,   col_cnt_in;
   logic [ROW_W-1:0] row_cnt_ff,   row_cnt_in;

   logic [31:0]       raw_id;
   logic [AREA_W-1:0] area_eff, area_m1;
   logic [COL_W-1:0]  width_eff;
   logic              id_done, is_last, do_emit;

   assign raw_id  = {req_data_byte, partial_ff};
   assign id_done = (byte_pos_ff == LAST_BYTE);

   always_comb begin
      area_eff = layer_area_ff;
      if (layer_area_ff == '0) begin
         area_eff = AREA_W'(1);
      end else if (layer_area_ff > AREA_MAX) begin
         area_eff = AREA_MAX;
      end
      area_m1   = area_eff - AREA_W'(1);
      width_eff = (layer_width_ff == '0) ? COL_W'(1) : layer_width_ff;
      is_last   = {1'b0, tile_cnt_ff} >= area_m1;
      do_emit   = !(skip_blank_ff && (raw_id == '0));
   end

   always_comb begin
      byte_pos_in = byte_pos_ff;
      partial_in  = partial_ff;
      tile_cnt_in = tile_cnt_ff;
      col_cnt_in  = col_cnt_ff;
      row_cnt_in  = row_cnt_ff;
      if (req_take) begin
         if (!id_done) begin
            // collect one byte, least significant first
            case (byte_pos_ff)
               2'd0:    partial_in[7:0]   = req_data_byte;
               2'd1:    partial_in[15:8]  = req_data_byte;
               default: partial_in[23:16] = req_data_byte;
            endcase
            byte_pos_in = byte_pos_ff + 2'd1;
         end else begin
            byte_pos_in = '0;
            partial_in  = '0;
            if (is_last) begin
               // end of layer: wrap all counters
               tile_cnt_in = '0;
               col_cnt_in  = '0;
               row_cnt_in  = '0;
            end else begin
               tile_cnt_in = tile_cnt_ff + NUM_W'(1);
               if ({1'b0, col_cnt_ff} + 17'd1 >= {1'b0, width_eff}) begin
                  col_cnt_in = '0;
                  row_cnt_in = row_cnt_ff + ROW_W'(1);
               end else begin
                  col_cnt_in = col_cnt_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         partial_ff  <= '0;
         tile_cnt_ff <= '0;
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
      end else begin
         byte_pos_ff <= byte_pos_in;
         partial_ff  <= partial_in;
         tile_cnt_ff <= tile_cnt_in;
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage A: grid word. Blank tiles skipped here never enter.
   // ------------------------------------------------------------------
   grid_word_type a_word_ff, a_word_in;
   logic          a_load;

   assign a_load = req_take && id_done && do_emit;

   always_comb begin
      a_word_in.tile_id     = raw_id[ID_W-1:0];
      a_word_in.flip_h      = raw_id[31];
      a_word_in.flip_v      = raw_id[30];
      a_word_in.flip_d      = raw_id[29];
      a_word_in.tile_number = tile_cnt_ff;
      a_word_in.column      = col_cnt_ff;
      a_word_in.row         = row_cnt_ff;
      a_word_in.last        = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_load) begin
         a_valid_ff <= 1'b1;
      end else if (a_adv) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_word_ff <= a_word_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage B: column and row scaled by the tile size.
   // ------------------------------------------------------------------
   prod_word_type b_word_ff, b_word_in;
   logic [31:0]   mul_x;
   logic [39:0]   mul_y;

   always_comb begin
      mul_x = a_word_ff.column * tile_width_ff;
      mul_y = a_word_ff.row * tile_height_ff;
      b_word_in.tile_id     = a_word_ff.tile_id;
      b_word_in.flip_h      = a_word_ff.flip_h;
      b_word_in.flip_v      = a_word_ff.flip_v;
      b_word_in.flip_d      = a_word_ff.flip_d;
      b_word_in.tile_number = a_word_ff.tile_number;
      b_word_in.prod_x      = mul_x;
      b_word_in.prod_y      = mul_y[POS_W-1:0];   // wrap at 32 bits
      b_word_in.last        = a_word_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_adv) begin
         b_valid_ff <= 1'b1;
      end else if (b_adv) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         b_word_ff <= b_word_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage C: add layer offsets into the output register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (b_adv) begin
         c_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         c_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         rsp_tile_id         <= b_word_ff.tile_id;
         rsp_flip_horizontal <= b_word_ff.flip_h;
         rsp_flip_vertical   <= b_word_ff.flip_v;
         rsp_flip_diagonal   <= b_word_ff.flip_d;
         rsp_tile_number     <= b_word_ff.tile_number;
         rsp_pixel_x         <= offset_x_ff + b_word_ff.prod_x;
         rsp_pixel_y         <= offset_y_ff + b_word_ff.prod_y;
         rsp_last_tile       <= b_word_ff.last;
      end
   end

   assign rsp_valid = c_valid_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_id_wraps_pos: assert property (@(posedge clock) disable iff (reset)
      (req_take && id_done) |=> (byte_pos_ff == 2'd0 && partial_ff == '0))
      else $error("byte position did not restart after a complete id");

   a_layer_end: assert property (@(posedge clock) disable iff (reset)
      (req_take && id_done && is_last) |=>
         (tile_cnt_ff == '0 && col_cnt_ff == '0 && row_cnt_ff == '0))
      else $error("counters did not wrap at end of layer");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && b_valid_ff && c_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   a_b_to_c: assert property (@(posedge clock) disable iff (reset)
      b_adv |=> c_valid_ff)
      else $error("word lost between multiply and output stage");

   a_skip_no_load: assert property (@(posedge clock) disable iff (reset)
      (req_take && id_done && !do_emit) |=> !a_valid_ff || $past(a_valid_ff))
      else $error("blank tile entered the pipeline");

endmodule

### tb/tile_word_checker.sv
`timescale 1ns / 100ps
// Tile word checker for the tile id stream decoder: follows the byte, tile word and
// register traffic, predicts each tile word and compares it field by field. Uses tgsd_pkg.
module tile_word_checker
   import tgsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [ID_W-1:0]      rsp_tile_id,
   input  logic                 rsp_flip_horizontal,
   input  logic                 rsp_flip_vertical,
   input  logic                 rsp_flip_diagonal,
   input  logic [NUM_W-1:0]     rsp_tile_number,
   input  logic [POS_W-1:0]     rsp_pixel_x,
   input  logic [POS_W-1:0]     rsp_pixel_y,
   input  logic                 rsp_last_tile,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_ADR_W-1:0] paddr,
   input  logic [CSR_DAT_W-1:0] pwdata,
   input  logic                 pready,
   output int                   fail_count,
   output int                   words_pending,
   output int                   words_checked
);

   typedef struct packed {
      logic [ID_W-1:0]  tile_id;
      logic             flip_h;
      logic             flip_v;
      logic             flip_d;
      logic [NUM_W-1:0] tile_number;
      logic [POS_W-1:0] pixel_x;
      logic [POS_W-1:0] pixel_y;
      logic             last;
   } tile_word_type;

   // register copy
   logic              skip_blank;
   logic [15:0]       layer_width;
   logic [AREA_W-1:0] layer_area;
   logic [15:0]       tile_w;
   logic [15:0]       tile_h;
   logic [POS_W-1:0]  off_x;
   logic [POS_W-1:0]  off_y;

   // place in the byte stream and in the layer
   logic [1:0]        byte_pos;
   logic [23:0]       partial_id;
   logic [NUM_W-1:0]  tile_count;
   logic [COL_W-1:0]  column;
   logic [ROW_W-1:0]  row;

   tile_word_type tiles_due[$];

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         flag_error($sformatf("%s is %h, %h predicted", name, got, want));
      end
   endtask

   task automatic write_register(input logic [CSR_ADR_W-1:0] addr,
                                 input logic [CSR_DAT_W-1:0] data);
      case (csr_index_type'(addr[CSR_ADR_W-1:2]))
         REG_SKIP_BLANK:  skip_blank  = data[0];
         REG_LAYER_WIDTH: layer_width = data[15:0];
         REG_LAYER_AREA:  layer_area  = data[AREA_W-1:0];
         REG_TILE_WIDTH:  tile_w      = data[15:0];
         REG_TILE_HEIGHT: tile_h      = data[15:0];
         REG_OFFSET_X:    off_x       = data;
         REG_OFFSET_Y:    off_y       = data;
         default: ;
      endcase
   endtask

   // Collect one byte; the fourth one completes an id and may predict a tile word.
   task automatic take_byte(input logic [7:0] data);
      logic [31:0]   raw;
      int unsigned   area;
      int unsigned   width;
      logic          at_end;
      tile_word_type word;
      if (byte_pos != LAST_BYTE) begin
         partial_id = partial_id | (24'(data) << (8 * byte_pos));
         byte_pos   = byte_pos + 2'd1;
      end else begin
         raw        = {data, partial_id};
         byte_pos   = '0;
         partial_id = '0;
         area  = (layer_area == '0) ? 1 : (layer_area > AREA_MAX) ? AREA_MAX : layer_area;
         width = (layer_width == '0) ? 1 : layer_width;
         at_end = (tile_count >= area - 1);
         if (!(skip_blank && raw == '0)) begin
            word.tile_id     = raw[ID_W-1:0];
            word.flip_h      = raw[31];
            word.flip_v      = raw[30];
            word.flip_d      = raw[29];
            word.tile_number = tile_count;
            word.pixel_x     = off_x + column * tile_w;
            word.pixel_y     = off_y + row * tile_h;
            word.last        = at_end;
            tiles_due.push_back(word);
         end
         if (at_end) begin
            tile_count = '0;
            column     = '0;
            row        = '0;
         end else begin
            tile_count = tile_count + 1'b1;
            if (column + 1 >= width) begin
               column = '0;
               row    = row + 1'b1;
            end else begin
               column = column + 1'b1;
            end
         end
      end
   endtask

   task automatic check_word();
      tile_word_type want;
      if (tiles_due.size() == 0) begin
         flag_error($sformatf("tile word %0d arrived with none pending", rsp_tile_number));
      end else begin
         want = tiles_due.pop_front();
         compare_field("tile_id", 32'(rsp_tile_id), 32'(want.tile_id));
         compare_field("flip_horizontal", 32'(rsp_flip_horizontal), 32'(want.flip_h));
         compare_field("flip_vertical", 32'(rsp_flip_vertical), 32'(want.flip_v));
         compare_field("flip_diagonal", 32'(rsp_flip_diagonal), 32'(want.flip_d));
         compare_field("tile_number", 32'(rsp_tile_number), 32'(want.tile_number));
         compare_field("pixel_x", rsp_pixel_x, want.pixel_x);
         compare_field("pixel_y", rsp_pixel_y, want.pixel_y);
         compare_field("last_tile", 32'(rsp_last_tile), 32'(want.last));
         words_checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         skip_blank    = 1'b0;
         layer_width   = 16'd1;
         layer_area    = 25'd1;
         tile_w        = 16'd1;
         tile_h        = 16'd1;
         off_x         = '0;
         off_y         = '0;
         byte_pos      = '0;
         partial_id    = '0;
         tile_count    = '0;
         column        = '0;
         row           = '0;
         fail_count    = 0;
         words_checked = 0;
         tiles_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_word();
         if (req_valid && !req_stall) take_byte(req_data_byte);
         if (psel && penable && pwrite && pready) write_register(paddr, pwdata);
      end
      words_pending = tiles_due.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the tile id stream decoder testbench: clock, reset, byte and register stimulus,
// output stalls and the verdict. Depends on tgsd_pkg, tile_word_checker and the block.
module testbench;
   import tgsd_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DRAIN_CYCLES  = 8;     // pipeline is three stages deep, plus margin
   localparam int HOLD_CYCLES   = 400;
   localparam int LAST_PHASE    = 11;
   localparam int IDS_PER_PHASE = 39;
   localparam int HOLD_PHASE    = 8;
   localparam logic [2:0] SPARE_INDEX = 3'd7;   // no register lives here

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_data_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ID_W-1:0]       rsp_tile_id;
   logic                  rsp_flip_horizontal;
   logic                  rsp_flip_vertical;
   logic                  rsp_flip_diagonal;
   logic [NUM_W-1:0]      rsp_tile_number;
   logic signed [POS_W-1:0] rsp_pixel_x;
   logic signed [POS_W-1:0] rsp_pixel_y;
   logic                  rsp_last_tile;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADR_W-1:0]  paddr;
   logic [CSR_DAT_W-1:0]  pwdata;
   logic [CSR_DAT_W-1:0]  prdata;
   logic                  pready;

   int fail_count;
   int words_pending;
   int words_checked;
   int cycle_count;
   int bytes_sent;
   int setups_done;
   int gap_mode;          // 0: sender never idles
   bit hold_request;      // ask the stall process for one long output hold

   tile_gid_stream_decoder dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_tile_id         (rsp_tile_id),
      .rsp_flip_horizontal (rsp_flip_horizontal),
      .rsp_flip_vertical   (rsp_flip_vertical),
      .rsp_flip_diagonal   (rsp_flip_diagonal),
      .rsp_tile_number     (rsp_tile_number),
      .rsp_pixel_x         (rsp_pixel_x),
      .rsp_pixel_y         (rsp_pixel_y),
      .rsp_last_tile       (rsp_last_tile),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // Watches both channels and the register port; predicts and compares every tile word.
   tile_word_checker check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_tile_id         (rsp_tile_id),
      .rsp_flip_horizontal (rsp_flip_horizontal),
      .rsp_flip_vertical   (rsp_flip_vertical),
      .rsp_flip_diagonal   (rsp_flip_diagonal),
      .rsp_tile_number     (rsp_tile_number),
      .rsp_pixel_x         (rsp_pixel_x),
      .rsp_pixel_y         (rsp_pixel_y),
      .rsp_last_tile       (rsp_last_tile),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .pready              (pready),
      .fail_count          (fail_count),
      .words_pending       (words_pending),
      .words_checked       (words_checked)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Cycle limit: end the run if the stimulus or the drain hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d tile words still pending",
               cycle_count, words_pending);
      $display("simulation failed");
      $finish;
   end

   // Output stall: random stretches of stall and of free flow, and on request one
   // long hold so that the pipeline fills and the block stalls its byte input.
   initial begin
      int unsigned pick;
      bit          hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 8)) @(negedge clock);
            end else if (pick < 80) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 3)) @(negedge clock);
            end else if (pick < 93) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(20, 60)) @(negedge clock);
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(10, 40)) @(negedge clock);
            end
         end
      end
   end

   // Sender gap before a byte: mostly none or short, a few long.
   function automatic int pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (gap_mode == 0 || pick < 70) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Raw id: blanks, flip-only and all-ones ids, small ids and fully random ones.
   function automatic logic [31:0] random_gid();
      logic [31:0]  gid;
      int unsigned  pick;
      pick = $urandom_range(0, 9);
      gid  = $urandom;
      case (pick)
         0, 1:       gid = '0;
         2:          gid = {gid[31:29], gid[0] ? 29'h1FFFFFFF : 29'h0};
         3, 4, 5, 6: gid = {gid[31:29], 29'($urandom_range(1, 400))};
         default: ;
      endcase
      return gid;
   endfunction

   // Offer one byte, hold it until accepted, return at the next falling edge.
   task automatic send_byte(input logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Send a raw id, least significant byte first.
   task automatic send_gid(input logic [31:0] gid);
      for (int i = 0; i < 4; i++) send_byte(gid[8*i +: 8]);
   endtask

   // One APB write: setup, then access until pready. Leave psel up for the next one.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Hold off until every predicted word has come out and the pipeline has emptied.
   task automatic wait_idle();
      while (words_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Register setup per phase. The first few hit the extremes; the order also leaves
   // counters beyond the new width or area, which must wrap at once.
   task automatic setup_phase(input int phase);
      logic              skip;
      logic [15:0]       lw;
      logic [AREA_W-1:0] la;
      logic [15:0]       tw;
      logic [15:0]       th;
      logic [31:0]       ox;
      logic [31:0]       oy;
      skip = 1'($urandom_range(0, 1));
      lw   = 16'($urandom_range(1, 9));
      la   = 25'($urandom_range(1, 50));
      tw   = 16'($urandom);
      th   = 16'($urandom);
      ox   = $urandom;
      oy   = $urandom;
      case (phase)
         0: begin
            skip = 1'b0; lw = 16'd3; la = 25'd5; tw = 16'd16; th = 16'd8;
            ox = 32'd100; oy = -32'sd50;
         end
         1: begin
            skip = 1'b1; lw = 16'd1; la = 25'd1; tw = 16'hFFFF; th = 16'hFFFF;
            ox = 32'h7FFFFFFF; oy = 32'h80000000;
         end
         2: begin
            skip = 1'b0; lw = 16'hFFFF; la = AREA_MAX; tw = 16'hFFFF; th = 16'hFFFF;
            ox = 32'hFFFFFFFF; oy = 32'h7FFF0000;
         end
         3: begin
            // zero width and zero area act as their fallbacks; zero tile size gives zero products
            skip = 1'b1; lw = '0; la = '0; tw = '0; th = '0;
            ox = 32'h80000000; oy = 32'h7FFFFFFF;
         end
         4: begin
            skip = 1'b0; lw = 16'd5; la = 25'h1FFFFFF; tw = 16'd1; th = 16'hFFFF;
         end
         5: begin
            skip = 1'b1; lw = 16'd2; la = 25'd3;
         end
         6: begin
            lw = 16'd40; la = 25'd1000;
         end
         7: begin
            lw = 16'd3; la = 25'd2000;
         end
         default: ;
      endcase
      csr_write(REG_SKIP_BLANK, 32'(skip));
      csr_write(REG_LAYER_WIDTH, 32'(lw));
      csr_write(REG_LAYER_AREA, 32'(la));
      csr_write(REG_TILE_WIDTH, 32'(tw));
      csr_write(REG_TILE_HEIGHT, 32'(th));
      csr_write(REG_OFFSET_X, ox);
      csr_write(REG_OFFSET_Y, oy);
      csr_write(SPARE_INDEX, $urandom);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      setups_done++;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      bytes_sent    = 0;
      setups_done   = 0;
      gap_mode      = 1;
      hold_request  = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: blank id, all bits set, largest id, then each flip on its own.
      setup_phase(0);
      send_gid(32'h00000000);
      send_gid(32'hFFFFFFFF);
      send_gid(32'h1FFFFFFF);
      send_gid(32'h80000000);
      send_gid(32'h40000000);
      send_gid(32'h20000000);
      req_valid <= 1'b0;

      // Random phases: well-formed ids with random content, a few stray bytes that
      // shift the id alignment, and a new register setup each time the block is idle.
      for (int phase = 1; phase <= LAST_PHASE; phase++) begin
         wait_idle();
         setup_phase(phase);
         gap_mode = $urandom_range(0, 3);
         if (phase == HOLD_PHASE) hold_request = 1'b1;
         repeat (IDS_PER_PHASE) begin
            if ($urandom_range(0, 39) == 0) send_byte(8'($urandom));
            send_gid(random_gid());
         end
         req_valid <= 1'b0;
      end

      wait_idle();
      $display("%0d bytes sent over %0d register setups, one %0d-cycle output hold",
               bytes_sent, setups_done, HOLD_CYCLES);
      $display("%0d tile words checked, %0d mismatches", words_checked, fail_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
